[rtl/ring_termination_detector_node_defines.svh]
// Assertion macros shared by the termination detector RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RING_TERMINATION_DETECTOR_NODE_DEFINES_SVH
`define RING_TERMINATION_DETECTOR_NODE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge of clk_i while rst_ni is high.
`define RTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge of clk_i, during reset as well.
`define RTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RTD_ASSERT(lbl, prop, msg)
`define RTD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/rtd_pkg.sv]
package rtd_pkg;

  localparam int MAX_NODES   = 16;
  localparam int STAMP_WIDTH = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int NODE_WIDTH  = 4;
  localparam int RING_WIDTH  = 5;

  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

  // Event opcodes.
  localparam logic [2:0] OP_BASIC_RECV = 3'd0;
  localparam logic [2:0] OP_BASIC_SEND = 3'd1;
  localparam logic [2:0] OP_LOCAL_WORK = 3'd2;
  localparam logic [2:0] OP_GO_PASSIVE = 3'd3;
  localparam logic [2:0] OP_CTRL_RECV  = 3'd4;
  localparam logic [2:0] OP_TERM_NOTE  = 3'd5;

  // Kinds of emitted messages.
  localparam logic [1:0] KIND_BASIC = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_TERM  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_NODE_ID   = 1'b0;
  localparam logic REG_RING_SIZE = 1'b1;

  typedef struct packed {
    logic [2:0]                    opcode;
    logic [STAMP_WIDTH-1:0]        msg_stamp;
    logic signed [COUNT_WIDTH-1:0] wave_count;
    logic                          wave_dirty;
    logic [NODE_WIDTH-1:0]         wave_initiator;
    logic [NODE_WIDTH-1:0]         peer;
  } item_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [NODE_WIDTH-1:0]         dest;
    logic [STAMP_WIDTH-1:0]        stamp;
    logic signed [COUNT_WIDTH-1:0] count;
    logic                          dirty;
    logic [NODE_WIDTH-1:0]         initiator;
    logic                          done;
  } result_t;

endpackage

[rtl/rtd_core.sv]
`include "ring_termination_detector_node_defines.svh"

module rtd_core
  import rtd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  item_t                 item_i,
  input  logic [NODE_WIDTH-1:0] node_id_i,
  input  logic [RING_WIDTH-1:0] ring_size_i,
  output logic                  emit_o,
  output result_t               result_o
);

  logic signed [COUNT_WIDTH-1:0] pc_q, pc_d;
  logic [STAMP_WIDTH-1:0]        clock_q, clock_d;
  logic [STAMP_WIDTH-1:0]        latest_q, latest_d;
  logic                          active_q, active_d;
  logic                          waiting_q, waiting_d;
  logic                          term_q, term_d;

  logic [RING_WIDTH-1:0]         next_raw;
  logic [NODE_WIDTH-1:0]         next_node;
  logic signed [COUNT_WIDTH:0]   fwd_sum;
  logic signed [COUNT_WIDTH-1:0] fwd_count;
  logic [STAMP_WIDTH-1:0]        clock_max;
  logic                          fwd_dirty;

  // Successor on the ring, wrapping at the ring size or at the node limit.
  assign next_raw  = RING_WIDTH'(node_id_i) + RING_WIDTH'(1);
  assign next_node = ((next_raw >= ring_size_i) || (next_raw >= RING_WIDTH'(MAX_NODES)))
                     ? '0 : next_raw[NODE_WIDTH-1:0];

  // Token count plus local count, saturated to the count range.
  assign fwd_sum = {item_i.wave_count[COUNT_WIDTH-1], item_i.wave_count}
                 + {pc_q[COUNT_WIDTH-1], pc_q};
  always_comb begin
    if (fwd_sum[COUNT_WIDTH] != fwd_sum[COUNT_WIDTH-1]) begin
      fwd_count = fwd_sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                                       : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    end else begin
      fwd_count = fwd_sum[COUNT_WIDTH-1:0];
    end
  end

  assign clock_max = (item_i.msg_stamp > clock_q) ? item_i.msg_stamp : clock_q;
  assign fwd_dirty = item_i.wave_dirty || (latest_q >= item_i.msg_stamp) || active_q;

  always_comb begin
    pc_d      = pc_q;
    clock_d   = clock_q;
    latest_d  = latest_q;
    active_d  = active_q;
    waiting_d = waiting_q;
    term_d    = term_q;
    emit_o    = 1'b0;
    result_o  = '0;
    if (!term_q) begin
      unique case (item_i.opcode)
        OP_BASIC_RECV: begin
          if (pc_q != {1'b1, {(COUNT_WIDTH-1){1'b0}}}) begin
            pc_d = pc_q - COUNT_WIDTH'(1);
          end
          if (item_i.msg_stamp > latest_q) begin
            latest_d = item_i.msg_stamp;
          end
        end
        OP_BASIC_SEND: begin
          if (pc_q != {1'b0, {(COUNT_WIDTH-1){1'b1}}}) begin
            pc_d = pc_q + COUNT_WIDTH'(1);
          end
          active_d       = 1'b1;
          emit_o         = 1'b1;
          result_o.kind  = KIND_BASIC;
          result_o.dest  = item_i.peer;
          result_o.stamp = clock_q;
        end
        OP_LOCAL_WORK: begin
          active_d = 1'b1;
        end
        OP_GO_PASSIVE: begin
          active_d = 1'b0;
          if (!waiting_q) begin
            if (clock_q != STAMP_MAX) begin
              clock_d = clock_q + STAMP_WIDTH'(1);
            end
            waiting_d          = 1'b1;
            emit_o             = 1'b1;
            result_o.kind      = KIND_TOKEN;
            result_o.dest      = next_node;
            result_o.stamp     = clock_d;
            result_o.count     = pc_q;
            result_o.initiator = node_id_i;
          end
        end
        OP_CTRL_RECV: begin
          clock_d = clock_max;
          if (item_i.wave_initiator == node_id_i) begin
            if ((item_i.wave_count == '0) && !item_i.wave_dirty) begin
              term_d             = 1'b1;
              emit_o             = 1'b1;
              result_o.kind      = KIND_TERM;
              result_o.stamp     = clock_max;
              result_o.initiator = node_id_i;
              result_o.done      = 1'b1;
            end else begin
              waiting_d = 1'b0;
              active_d  = 1'b1;
            end
          end else begin
            emit_o             = 1'b1;
            result_o.kind      = KIND_TOKEN;
            result_o.dest      = next_node;
            result_o.stamp     = item_i.msg_stamp;
            result_o.count     = fwd_count;
            result_o.dirty     = fwd_dirty;
            result_o.initiator = item_i.wave_initiator;
          end
        end
        OP_TERM_NOTE: begin
          term_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      clock_q   <= '0;
      latest_q  <= '0;
      active_q  <= 1'b1;
      waiting_q <= 1'b0;
      term_q    <= 1'b0;
    end else if (fire_i) begin
      pc_q      <= pc_d;
      clock_q   <= clock_d;
      latest_q  <= latest_d;
      active_q  <= active_d;
      waiting_q <= waiting_d;
      term_q    <= term_d;
    end
  end

  `RTD_ASSERT(a_term_sticky, term_q |=> term_q, "terminated flag dropped")
  `RTD_ASSERT_ALWAYS(a_term_silent, term_q |-> !emit_o, "result after termination")
  `RTD_ASSERT(a_passive_waits,
    (fire_i && !term_q && (item_i.opcode == OP_GO_PASSIVE)) |=> waiting_q,
    "go passive did not leave the node waiting")

endmodule

[rtl/ring_termination_detector_node.sv]
// A beat taken from the input waits in the input register; its result is loaded into the
// result register when the beat advances, and the sink takes it from there.
// Throughput: one event per cycle while results are taken. A held result stalls the
// input only once an event that produces a result sits in the input register.
// Events that produce no result pass even while the result register is held.
// Reset (rst_ni low, asynchronous) empties both registers and restores node state.
`include "ring_termination_detector_node_defines.svh"

module ring_termination_detector_node
  import rtd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [STAMP_WIDTH-1:0]        msg_stamp_i,
  input  logic signed [COUNT_WIDTH-1:0] wave_count_i,
  input  logic                          wave_dirty_i,
  input  logic [NODE_WIDTH-1:0]         wave_initiator_i,
  input  logic [NODE_WIDTH-1:0]         peer_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [NODE_WIDTH-1:0]         dest_o,
  output logic [STAMP_WIDTH-1:0]        out_stamp_o,
  output logic signed [COUNT_WIDTH-1:0] out_count_o,
  output logic                          out_dirty_o,
  output logic [NODE_WIDTH-1:0]         out_initiator_o,
  output logic                          done_res_o
);

  // Configuration registers. The register index is the word address, so
  // node_id sits at byte address 0 and ring_size at byte address 4.
  logic [NODE_WIDTH-1:0] node_id_q;
  logic [RING_WIDTH-1:0] ring_size_q;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      ring_size_q <= RING_WIDTH'(4);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_NODE_ID:   node_id_q   <= pwdata[NODE_WIDTH-1:0];
        REG_RING_SIZE: ring_size_q <= pwdata[RING_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_ID:   prdata = 32'(node_id_q);
      REG_RING_SIZE: prdata = 32'(ring_size_q);
      default:       prdata = '0;
    endcase
  end

  // Input register. A beat sits here while the node state is read and the
  // result is formed; it leaves when the result register can take its
  // result, or at once if the event produces none.
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    in_accept;
  logic    s1_adv;
  logic    out_free;
  logic    core_emit;
  result_t core_result;

  logic    out_valid_q;
  result_t out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (out_free || !core_emit);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= '{opcode:         opcode_i,
                     msg_stamp:      msg_stamp_i,
                     wave_count:     wave_count_i,
                     wave_dirty:     wave_dirty_i,
                     wave_initiator: wave_initiator_i,
                     peer:           peer_i};
    end
  end

  // Node state and event decode. State commits when the beat advances.
  rtd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_adv),
    .item_i      (s1_item_q),
    .node_id_i   (node_id_q),
    .ring_size_i (ring_size_q),
    .emit_o      (core_emit),
    .result_o    (core_result)
  );

  // Result register. It reloads in the same cycle that its beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && core_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && core_emit) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign dest_o          = out_q.dest;
  assign out_stamp_o     = out_q.stamp;
  assign out_count_o     = out_q.count;
  assign out_dirty_o     = out_q.dirty;
  assign out_initiator_o = out_q.initiator;
  assign done_res_o      = out_q.done;

  // A beat that overtakes a held result must be one that produces nothing.
  `RTD_ASSERT(a_no_overwrite, (s1_adv && !out_free) |-> !core_emit,
    "result register overwritten while held")
  // The input only stalls behind a beat that is really waiting.
  `RTD_ASSERT(a_stall_cause, in_stall_o |-> (s1_valid_q && core_emit && !out_free),
    "input stalled without a waiting result")
  // A stalled result stays offered and does not change.
  `RTD_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_q)),
    "stalled result changed or vanished")

endmodule

[tb/tb_ring_termination_detector_node.sv]
`timescale 1ns / 1ps

module tb_ring_termination_detector_node;
  import rtd_pkg::*;

  // Opcodes that the node has no meaning for; it must drop them without a result.
  localparam logic [2:0] OP_RESERVED_A = 3'd6;
  localparam logic [2:0] OP_RESERVED_B = 3'd7;

  localparam int COUNT_MAX = 2 ** (COUNT_WIDTH - 1) - 1;
  localparam int COUNT_MIN = -(2 ** (COUNT_WIDTH - 1));

  // A result passes through the input register and then the result register, and events
  // that produce nothing may still sit in the input register; the settle wait covers them.
  localparam int SETTLE_CYCLES = 4;
  // Longest stretch without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 84;
  localparam int NUM_PHASES    = 9;

  // Ring positions and ring sizes for the random phases. Sizes 0, 1 and 31 are
  // outside the legal range and exercise the wrap of the next-node rule.
  localparam int PHASE_NODE_IDS   [NUM_PHASES] = '{0, 15, 1, 15, 5, 7, 0, 9, 14};
  localparam int PHASE_RING_SIZES [NUM_PHASES] = '{2, 16, 16, 31, 0, 1, 16, 12, 3};

  // Mirror of one ring node: it tracks the node's counters and flags and keeps
  // the messages the node is expected to emit, oldest first.
  class ring_node_mirror;
    logic [NODE_WIDTH-1:0]         node_id;
    logic [RING_WIDTH-1:0]         ring_size;
    logic signed [COUNT_WIDTH-1:0] pending;
    logic [STAMP_WIDTH-1:0]        lclock;
    logic [STAMP_WIDTH-1:0]        latest_seen;
    bit                            active;
    bit                            waiting;
    bit                            terminated;
    result_t                       outbound_q[$];
    int                            errors;

    function new();
      node_id     = '0;
      ring_size   = RING_WIDTH'(4);
      pending     = '0;
      lclock      = '0;
      latest_seen = '0;
      active      = 1'b1;
      waiting     = 1'b0;
      terminated  = 1'b0;
      errors      = 0;
    endfunction

    function logic signed [COUNT_WIDTH-1:0] clamp_count(int v);
      if (v > COUNT_MAX) return COUNT_MAX[COUNT_WIDTH-1:0];
      if (v < COUNT_MIN) return COUNT_MIN[COUNT_WIDTH-1:0];
      return v[COUNT_WIDTH-1:0];
    endfunction

    // The successor wraps at the ring size or at the node limit, whichever
    // comes first, so a ring size of zero is harmless.
    function logic [NODE_WIDTH-1:0] next_hop();
      int n;
      n = int'(node_id) + 1;
      if (n >= int'(ring_size) || n >= MAX_NODES) n = 0;
      return n[NODE_WIDTH-1:0];
    endfunction

    // Appends an expected message behind the ones already queued.
    function void queue_message(result_t msg);
      outbound_q.insert(outbound_q.size(), msg);
    endfunction

    function void take_event(item_t ev);
      result_t msg;
      logic signed [COUNT_WIDTH-1:0] wcount;
      msg = '0;
      wcount = $signed(ev.wave_count);
      if (terminated) return;
      case (ev.opcode)
        OP_BASIC_RECV: begin
          pending = clamp_count(int'(pending) - 1);
          if (ev.msg_stamp > latest_seen) latest_seen = ev.msg_stamp;
        end
        OP_BASIC_SEND: begin
          pending   = clamp_count(int'(pending) + 1);
          active    = 1'b1;
          msg.kind  = KIND_BASIC;
          msg.dest  = ev.peer;
          msg.stamp = lclock;
          queue_message(msg);
        end
        OP_LOCAL_WORK: active = 1'b1;
        OP_GO_PASSIVE: begin
          active = 1'b0;
          if (!waiting) begin
            if (lclock != STAMP_MAX) lclock = lclock + 1'b1;
            waiting       = 1'b1;
            msg.kind      = KIND_TOKEN;
            msg.dest      = next_hop();
            msg.stamp     = lclock;
            msg.count     = pending;
            msg.initiator = node_id;
            queue_message(msg);
          end
        end
        OP_CTRL_RECV: begin
          if (ev.msg_stamp > lclock) lclock = ev.msg_stamp;
          if (ev.wave_initiator == node_id) begin
            // Our own wave came back: clean and balanced means global termination.
            if (wcount == 0 && !ev.wave_dirty) begin
              terminated    = 1'b1;
              msg.kind      = KIND_TERM;
              msg.stamp     = lclock;
              msg.initiator = node_id;
              msg.done      = 1'b1;
              queue_message(msg);
            end else begin
              waiting = 1'b0;
              active  = 1'b1;
            end
          end else begin
            msg.kind      = KIND_TOKEN;
            msg.dest      = next_hop();
            msg.stamp     = ev.msg_stamp;
            msg.count     = clamp_count(int'(wcount) + int'(pending));
            msg.dirty     = ev.wave_dirty || (latest_seen >= ev.msg_stamp) || active;
            msg.initiator = ev.wave_initiator;
            queue_message(msg);
          end
        end
        OP_TERM_NOTE: terminated = 1'b1;
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_message(result_t got);
      result_t want;
      if (outbound_q.size() == 0) begin
        $error("message with none expected: kind %0d, dest %0d", got.kind, got.dest);
        errors++;
        return;
      end
      want = outbound_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("dest", 32'(want.dest), 32'(got.dest));
      check_field("out_stamp", 32'(want.stamp), 32'(got.stamp));
      check_field("out_count", 32'($signed(want.count)), 32'($signed(got.count)));
      check_field("out_dirty", 32'(want.dirty), 32'(got.dirty));
      check_field("out_initiator", 32'(want.initiator), 32'(got.initiator));
      check_field("done_res", 32'(want.done), 32'(got.done));
    endfunction
  endclass

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          psel             = 1'b0;
  logic                          penable          = 1'b0;
  logic                          pwrite           = 1'b0;
  logic [2:0]                    paddr            = '0;
  logic [31:0]                   pwdata           = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic [2:0]                    opcode_i         = '0;
  logic [STAMP_WIDTH-1:0]        msg_stamp_i      = '0;
  logic signed [COUNT_WIDTH-1:0] wave_count_i     = '0;
  logic                          wave_dirty_i     = 1'b0;
  logic [NODE_WIDTH-1:0]         wave_initiator_i = '0;
  logic [NODE_WIDTH-1:0]         peer_i           = '0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b0;
  logic [1:0]                    kind_o;
  logic [NODE_WIDTH-1:0]         dest_o;
  logic [STAMP_WIDTH-1:0]        out_stamp_o;
  logic signed [COUNT_WIDTH-1:0] out_count_o;
  logic                          out_dirty_o;
  logic [NODE_WIDTH-1:0]         out_initiator_o;
  logic                          done_res_o;

  ring_node_mirror mirror;
  // When set, both the event source and the message sink insert random pauses.
  bit idle_en = 1'b0;
  int quiet_cycles = 0;

  ring_termination_detector_node dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .msg_stamp_i      (msg_stamp_i),
    .wave_count_i     (wave_count_i),
    .wave_dirty_i     (wave_dirty_i),
    .wave_initiator_i (wave_initiator_i),
    .peer_i           (peer_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .dest_o           (dest_o),
    .out_stamp_o      (out_stamp_o),
    .out_count_o      (out_count_o),
    .out_dirty_o      (out_dirty_o),
    .out_initiator_o  (out_initiator_o),
    .done_res_o       (done_res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The message sink stalls in random bursts. At most one decision is made at each falling
  // edge, so the stall line is never toggled twice in a step.
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Every message beat taken by the sink is compared against the oldest one
  // the mirror expects. Outputs are sampled at the rising edge, before the
  // node's registers update.
  always @(posedge clk_i) begin : take_message
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind      = kind_o;
      got.dest      = dest_o;
      got.stamp     = out_stamp_o;
      got.count     = out_count_o;
      got.dirty     = out_dirty_o;
      got.initiator = out_initiator_o;
      got.done      = done_res_o;
      mirror.check_message(got);
    end
  end

  // Hang detection: any beat on either channel or a register access resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no handshake for %0d cycles, %0d messages still expected",
             quiet_cycles, mirror.outbound_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic item_t make_item(logic [2:0] op, logic [STAMP_WIDTH-1:0] stamp,
                                      logic signed [COUNT_WIDTH-1:0] cnt, logic dirty,
                                      logic [NODE_WIDTH-1:0] init,
                                      logic [NODE_WIDTH-1:0] dest);
    item_t ev;
    ev.opcode         = op;
    ev.msg_stamp      = stamp;
    ev.wave_count     = cnt;
    ev.wave_dirty     = dirty;
    ev.wave_initiator = init;
    ev.peer           = dest;
    return ev;
  endfunction

  // Random event shaped like real ring traffic. Stamps mostly hover around the
  // node's own clock so that the "seen a newer message" compare goes both ways;
  // token counts mostly cancel the local count so that balanced waves occur.
  // With wide set, stamps also hit the top of the range and full random values.
  // A returning own wave is never allowed to be clean and balanced here, since
  // that would end the node's life in the middle of the run.
  function automatic item_t random_event(bit wide);
    item_t ev;
    int pick;
    int roll;
    int base;
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 9);
    if (wide && roll == 0) begin
      ev.msg_stamp = '1;
    end else if (wide && roll < 3) begin
      ev.msg_stamp = STAMP_WIDTH'($urandom);
    end else if (roll == 3) begin
      ev.msg_stamp = '0;
    end else begin
      base = int'(mirror.lclock) + int'($urandom_range(0, 6)) - 3;
      if (base < 0) base = 0;
      if (base > int'(STAMP_MAX)) base = int'(STAMP_MAX);
      ev.msg_stamp = base[STAMP_WIDTH-1:0];
    end
    case ($urandom_range(0, 9))
      0:       ev.wave_count = COUNT_MAX[COUNT_WIDTH-1:0];
      1:       ev.wave_count = COUNT_MIN[COUNT_WIDTH-1:0];
      2:       ev.wave_count = COUNT_WIDTH'($urandom);
      default: ev.wave_count = COUNT_WIDTH'(-int'(mirror.pending)
                                            + int'($urandom_range(0, 4)) - 2);
    endcase
    ev.wave_dirty     = 1'($urandom_range(0, 1));
    ev.wave_initiator = NODE_WIDTH'($urandom_range(0, 15));
    ev.peer           = NODE_WIDTH'($urandom_range(0, 15));
    if (pick < 18) begin
      ev.opcode = OP_BASIC_RECV;
    end else if (pick < 38) begin
      ev.opcode = OP_BASIC_SEND;
    end else if (pick < 48) begin
      ev.opcode = OP_LOCAL_WORK;
    end else if (pick < 63) begin
      ev.opcode = OP_GO_PASSIVE;
    end else if (pick < 95) begin
      ev.opcode = OP_CTRL_RECV;
      // About half the time a wave we started comes back, carrying our clock.
      if (mirror.waiting && $urandom_range(0, 1)) begin
        ev.wave_initiator = mirror.node_id;
        ev.msg_stamp      = mirror.lclock;
      end
    end else begin
      ev.opcode = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
    end
    if (ev.wave_initiator == mirror.node_id && ev.wave_count == 0 && !ev.wave_dirty) begin
      ev.wave_dirty = 1'b1;
    end
    return ev;
  endfunction

  // Offers one event beat and holds it until the node takes it. Called at a
  // falling edge and returns at one, possibly after a short pause with valid low.
  task automatic send_event(item_t ev);
    opcode_i         = ev.opcode;
    msg_stamp_i      = ev.msg_stamp;
    wave_count_i     = ev.wave_count;
    wave_dirty_i     = ev.wave_dirty;
    wave_initiator_i = ev.wave_initiator;
    peer_i           = ev.peer;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    mirror.take_event(ev);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Writes a register with a setup and an access cycle, then reads it back.
  task automatic set_register(logic idx, int value);
    logic [2:0] addr;
    addr = {idx, 2'b00};
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_NODE_ID) begin
      mirror.node_id = value[NODE_WIDTH-1:0];
    end else begin
      mirror.ring_size = value[RING_WIDTH-1:0];
    end
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $error("register %0d read back: expected %0d, got %0d", idx, value, prdata);
      mirror.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Stops the event source and waits until every expected message has been
  // taken, then lets events with no result leave the pipeline as well.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (mirror.outbound_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    item_t ev;
    mirror = new();

    // Reset is held at the start and released on a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: node 3 in a ring of four, so its successor wraps to 0.
    idle_en = 1'b1;
    set_register(REG_NODE_ID, 3);
    set_register(REG_RING_SIZE, 4);
    send_event(make_item(OP_BASIC_SEND, '0, '0, 1'b0, '0, 4'd15));
    send_event(make_item(OP_BASIC_SEND, '1, -16'sd1, 1'b1, 4'd15, 4'd0));
    // Foreign token whose count overflows at the top.
    send_event(make_item(OP_CTRL_RECV, 16'd10, COUNT_MAX[COUNT_WIDTH-1:0], 1'b0, 4'd0, 4'd0));
    repeat (3) send_event(make_item(OP_BASIC_RECV, 16'd3, '0, 1'b0, '0, '0));
    send_event(make_item(OP_LOCAL_WORK, '0, '0, 1'b0, '0, '0));
    // Going passive starts a clean wave; doing it again while waiting does nothing.
    send_event(make_item(OP_GO_PASSIVE, '0, '0, 1'b0, '0, '0));
    send_event(make_item(OP_GO_PASSIVE, '1, '1, 1'b1, '1, '1));
    // Passive node, no newer messages: the forwarded token stays clean, and
    // its count overflows at the bottom.
    send_event(make_item(OP_CTRL_RECV, 16'd20, COUNT_MIN[COUNT_WIDTH-1:0], 1'b0, 4'd1, 4'd0));
    send_event(make_item(OP_CTRL_RECV, 16'd2, '0, 1'b1, 4'd15, 4'd15));
    // Own wave returns dirty, then unbalanced: both wake the node up again.
    send_event(make_item(OP_CTRL_RECV, 16'd5, '0, 1'b1, 4'd3, 4'd0));
    send_event(make_item(OP_GO_PASSIVE, '0, '0, 1'b0, '0, '0));
    send_event(make_item(OP_CTRL_RECV, 16'd21, 16'sd5, 1'b0, 4'd3, 4'd0));
    // Unknown opcodes are dropped.
    send_event(make_item(OP_RESERVED_A, '1, '1, 1'b1, '1, '1));
    send_event(make_item(OP_RESERVED_B, '1, '1, 1'b1, '1, '1));
    send_event(make_item(OP_GO_PASSIVE, '0, '0, 1'b0, '0, '0));
    // A token stamped exactly at the latest seen message counts as dirty.
    send_event(make_item(OP_CTRL_RECV, 16'd3, 16'sd1, 1'b0, 4'd2, 4'd0));
    drain_results();

    // Random phases, each under its own ring setting. Every third phase runs
    // without pauses, and the later half uses stamps across the whole range.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_register(REG_NODE_ID, PHASE_NODE_IDS[phase]);
      set_register(REG_RING_SIZE, PHASE_RING_SIZES[phase]);
      idle_en = (phase % 3 != 2);
      repeat (PHASE_ITEMS) send_event(random_event(phase >= NUM_PHASES / 2));
      drain_results();
    end

    // Final part, back to back with no pauses. The clock is pushed to its top
    // and must stay there when a wave starts.
    idle_en = 1'b0;
    set_register(REG_NODE_ID, 2);
    set_register(REG_RING_SIZE, 8);
    send_event(make_item(OP_CTRL_RECV, '0, '0, 1'b1, mirror.node_id, 4'd0));
    send_event(make_item(OP_CTRL_RECV, '1, 16'sd7, 1'b0, 4'd7, 4'd0));
    send_event(make_item(OP_GO_PASSIVE, '0, '0, 1'b0, '0, '0));
    send_event(make_item(OP_CTRL_RECV, '0, '0, 1'b1, mirror.node_id, 4'd0));
    send_event(make_item(OP_GO_PASSIVE, '0, '0, 1'b0, '0, '0));

    // The node can terminate only once per run. Either its own clean, balanced
    // wave returns and it broadcasts, or a neighbor tells it. Afterwards every
    // event, whatever the opcode, must be ignored.
    if ($urandom_range(0, 1)) begin
      send_event(make_item(OP_CTRL_RECV, '0, '0, 1'b0, mirror.node_id, 4'd0));
    end else begin
      send_event(make_item(OP_TERM_NOTE, '0, '0, 1'b0, '0, '0));
    end
    repeat (20) begin
      ev = random_event(1'b1);
      ev.opcode = 3'($urandom);
      send_event(ev);
    end
    drain_results();

    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rtd_pkg.sv
rtl/rtd_core.sv
rtl/ring_termination_detector_node.sv
tb/tb_ring_termination_detector_node.sv
